### design/etf_pkg.sv
// shared types, constants and the sine table builder for the triangle fan generator
package etf_pkg;

    localparam int MAX_SEGMENTS_DEF     = 64;
    localparam int SINE_TABLE_DEPTH_DEF = 256;
    localparam int COORD_WIDTH          = 16;

    localparam int COORD_W   = 16;
    localparam int RADIUS_W  = 15;
    localparam int TRIG_W    = 15;
    localparam int COUNT_W   = 7;
    localparam int PHASE_W   = 16;
    localparam int QUO_W     = PHASE_W + 1;
    localparam int DIV_STEPS = QUO_W;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] Q30_ONE     = 64'd1073741824;

    localparam logic signed [63:0] SAT_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1;
    localparam logic signed [63:0] SAT_LO = -SAT_HI - 64'sd1;

    typedef struct packed {
        logic load;
        logic div_step;
        logic issue_x;
        logic issue_y;
        logic store;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic last;
    } t_status;

    // quarter-wave entry from an angle in Q2.30
    function automatic logic [TRIG_W-1:0] sine_entry(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] v;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - (((x2 * t) >> 30) / 156);
        t  = Q30_ONE - (((x2 * t) >> 30) / 110);
        t  = Q30_ONE - (((x2 * t) >> 30) / 72);
        t  = Q30_ONE - (((x2 * t) >> 30) / 42);
        t  = Q30_ONE - (((x2 * t) >> 30) / 20);
        t  = Q30_ONE - (((x2 * t) >> 30) / 6);
        s  = (x * t) >> 30;
        v  = (s + 64'd16384) >> 15;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[TRIG_W-1:0];
    endfunction

endpackage

### design/ellipse_triangle_fan_generator.sv
// top level of the ellipse triangle fan generator
//
// An ellipse is taken when start is high and busy is low: center, two radii
// and a segment count n (counts above the segment limit are clamped, zero
// gives no triangles and the block stays idle).
// The block then emits n triangle beats, each held on the o_ ports for one
// cycle while o_result_valid is high: apex, rim vertex i, rim vertex
// (i+1) mod n, a saturation flag and a flag on the last beat.
// The bit-serial phase step divider runs first, then each rim vertex in
// turn takes two table lookups through one shared multiplier and the
// round and saturate stage; busy drops in the cycle that shows the last
// beat, so a new item may be taken then.
// The receiver has no back-pressure: every beat must be taken when shown.
// Reset (synchronous, active low) returns the controller to idle and
// drops o_result_valid; the sine table is constant logic and needs no fill.
module ellipse_triangle_fan_generator #(
    parameter int MAX_SEGMENTS     = etf_pkg::MAX_SEGMENTS_DEF,
    parameter int SINE_TABLE_DEPTH = etf_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [etf_pkg::COORD_W-1:0]    i_center_x,
    input  logic signed [etf_pkg::COORD_W-1:0]    i_center_y,
    input  logic        [etf_pkg::RADIUS_W-1:0]   i_radius_horizontal,
    input  logic        [etf_pkg::RADIUS_W-1:0]   i_radius_vertical,
    input  logic        [etf_pkg::COUNT_W-1:0]    i_segment_count,
    output logic                                  o_result_valid,
    output logic signed [etf_pkg::COORD_W-1:0]    o_apex_x,
    output logic signed [etf_pkg::COORD_W-1:0]    o_apex_y,
    output logic signed [etf_pkg::COORD_W-1:0]    o_rim_a_x,
    output logic signed [etf_pkg::COORD_W-1:0]    o_rim_a_y,
    output logic signed [etf_pkg::COORD_W-1:0]    o_rim_b_x,
    output logic signed [etf_pkg::COORD_W-1:0]    o_rim_b_y,
    output logic                                  o_clipped,
    output logic                                  o_final_triangle
);

    etf_pkg::t_cmd    w_cmd;
    etf_pkg::t_status w_status;

    etf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .busy     (busy)
    );

    etf_datapath #(
        .MAX_SEGMENTS     (MAX_SEGMENTS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .o_status            (w_status),
        .i_center_x          (i_center_x),
        .i_center_y          (i_center_y),
        .i_radius_horizontal (i_radius_horizontal),
        .i_radius_vertical   (i_radius_vertical),
        .i_segment_count     (i_segment_count),
        .o_result_valid      (o_result_valid),
        .o_apex_x            (o_apex_x),
        .o_apex_y            (o_apex_y),
        .o_rim_a_x           (o_rim_a_x),
        .o_rim_a_y           (o_rim_a_y),
        .o_rim_b_x           (o_rim_b_x),
        .o_rim_b_y           (o_rim_b_y),
        .o_clipped           (o_clipped),
        .o_final_triangle    (o_final_triangle)
    );

endmodule

### design/etf_ctrl.sv
// controller state machine: divide, per-vertex issue, wait, store, final beat
module etf_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  etf_pkg::t_status i_status,
    output etf_pkg::t_cmd   o_cmd,
    output logic            busy
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_DIVIDE  = 7'b0000010,
        S_ISSUE_X = 7'b0000100,
        S_ISSUE_Y = 7'b0001000,
        S_WAIT    = 7'b0010000,
        S_STORE   = 7'b0100000,
        S_FINAL   = 7'b1000000
    } t_state;

    localparam int CNT_W = $clog2(etf_pkg::DIV_STEPS);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [CNT_W-1:0]   n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    if (!i_status.empty) begin
                        n_state = S_DIVIDE;
                    end
                end
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(etf_pkg::DIV_STEPS - 1)) begin
                    n_state = S_ISSUE_X;
                end
            end
            S_ISSUE_X: begin
                o_cmd.issue_x = 1'b1;
                n_state       = S_ISSUE_Y;
            end
            S_ISSUE_Y: begin
                o_cmd.issue_y = 1'b1;
                n_cnt         = '0;
                n_state       = S_WAIT;
            end
            S_WAIT: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(2)) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_status.last ? S_FINAL : S_ISSUE_X;
            end
            S_FINAL: begin
                o_cmd.emit_final = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

### design/etf_datapath.sv
// datapath: phase divider, sine lookup, scale and saturate pipeline, vertex and beat registers
module etf_datapath #(
    parameter int MAX_SEGMENTS     = etf_pkg::MAX_SEGMENTS_DEF,
    parameter int SINE_TABLE_DEPTH = etf_pkg::SINE_TABLE_DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  etf_pkg::t_cmd                         i_cmd,
    output etf_pkg::t_status                      o_status,
    input  logic signed [etf_pkg::COORD_W-1:0]    i_center_x,
    input  logic signed [etf_pkg::COORD_W-1:0]    i_center_y,
    input  logic        [etf_pkg::RADIUS_W-1:0]   i_radius_horizontal,
    input  logic        [etf_pkg::RADIUS_W-1:0]   i_radius_vertical,
    input  logic        [etf_pkg::COUNT_W-1:0]    i_segment_count,
    output logic                                  o_result_valid,
    output logic signed [etf_pkg::COORD_W-1:0]    o_apex_x,
    output logic signed [etf_pkg::COORD_W-1:0]    o_apex_y,
    output logic signed [etf_pkg::COORD_W-1:0]    o_rim_a_x,
    output logic signed [etf_pkg::COORD_W-1:0]    o_rim_a_y,
    output logic signed [etf_pkg::COORD_W-1:0]    o_rim_b_x,
    output logic signed [etf_pkg::COORD_W-1:0]    o_rim_b_y,
    output logic                                  o_clipped,
    output logic                                  o_final_triangle
);

    localparam int CW  = etf_pkg::COORD_W;
    localparam int RW  = etf_pkg::RADIUS_W;
    localparam int TW  = etf_pkg::TRIG_W;
    localparam int PW  = etf_pkg::PHASE_W;
    localparam int QW  = etf_pkg::QUO_W;
    localparam int NW  = $clog2(MAX_SEGMENTS + 1);
    localparam int IW  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int JW  = 15 + IW;
    localparam int OW  = PW - 2;
    localparam int SW  = CW + 2;

    // quarter-wave sine table
    logic [TW-1:0] w_rom [0:SINE_TABLE_DEPTH];

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
        localparam logic [63:0] ANGLE =
            (64'(g) * etf_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
        assign w_rom[g] = etf_pkg::sine_entry(ANGLE);
    end

    function automatic logic [CW:0] sat_coord(input logic signed [63:0] v);
        logic [CW:0] r;
        r = {1'b0, v[CW-1:0]};
        if (v > etf_pkg::SAT_HI) begin
            r = {1'b1, CW'(etf_pkg::SAT_HI)};
        end else if (v < etf_pkg::SAT_LO) begin
            r = {1'b1, CW'(etf_pkg::SAT_LO)};
        end
        return r;
    endfunction

    // item registers
    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic [RW-1:0]        r_rx;
    logic [RW-1:0]        r_ry;
    logic [NW-1:0]        r_n;
    logic signed [CW-1:0] r_apex_x;
    logic signed [CW-1:0] r_apex_y;
    logic                 r_aclip;

    // phase step divider and accumulator
    logic [QW-1:0]        r_quo;
    logic [NW-1:0]        r_rem;
    logic [PW-1:0]        r_phase;
    logic [NW-1:0]        r_frac;
    logic [NW-1:0]        r_k;

    // lookup pipeline
    logic                 r_v1, r_v2, r_v3;
    logic                 r_ax1, r_ax2, r_ax3;
    logic                 r_neg1, r_neg2, r_neg3;
    logic [IW-1:0]        r_idx;
    logic [TW-1:0]        r_trig;
    logic [RW+TW-1:0]     r_prod;

    // vertex registers
    logic signed [CW-1:0] r_cur_x, r_cur_y;
    logic                 r_clip_x, r_clip_y;
    logic signed [CW-1:0] r_prev_x, r_prev_y;
    logic                 r_prev_clip;
    logic signed [CW-1:0] r_v0_x, r_v0_y;
    logic                 r_v0_clip;

    // result beat
    logic                 r_valid;
    logic signed [CW-1:0] r_out_ax, r_out_ay, r_out_a_x, r_out_a_y, r_out_b_x, r_out_b_y;
    logic                 r_out_clip, r_out_final;

    logic [NW-1:0]        w_n_in;
    logic [CW:0]          w_apex_x_sat, w_apex_y_sat;
    logic [NW:0]          w_trial;
    logic                 w_qbit;
    logic [NW-1:0]        w_rem_next;
    logic [NW:0]          w_frac_sum;
    logic                 w_carry;
    logic [PW-1:0]        w_ph;
    logic [JW-1:0]        w_jprod;
    logic [IW-1:0]        w_j;
    logic [IW-1:0]        w_idx;
    logic signed [31:0]   w_sprod;
    logic signed [31:0]   w_round;
    logic signed [31:0]   w_shift;
    logic signed [CW-1:0] w_center;
    logic signed [SW-1:0] w_sum;
    logic [CW:0]          w_sat;
    logic                 w_cur_clip;

    assign w_n_in = (i_segment_count > etf_pkg::COUNT_W'(MAX_SEGMENTS))
                  ? NW'(MAX_SEGMENTS) : i_segment_count[NW-1:0];

    assign w_apex_x_sat = sat_coord({{(64-CW){i_center_x[CW-1]}}, i_center_x});
    assign w_apex_y_sat = sat_coord({{(64-CW){i_center_y[CW-1]}}, i_center_y});

    // restoring divide of one full turn by the segment count
    assign w_trial    = {r_rem, r_quo[QW-1]};
    assign w_qbit     = (w_trial >= {1'b0, r_n});
    assign w_rem_next = w_qbit ? NW'(w_trial - {1'b0, r_n}) : w_trial[NW-1:0];

    assign w_frac_sum = {1'b0, r_frac} + {1'b0, r_rem};
    assign w_carry    = (w_frac_sum >= {1'b0, r_n});

    // table index from phase
    assign w_ph    = i_cmd.issue_x ? (r_phase + PW'(16384)) : r_phase;
    assign w_jprod = JW'(w_ph[OW-1:0]) * JW'(SINE_TABLE_DEPTH) + JW'(8192);
    assign w_j     = IW'(w_jprod[JW-1:OW]);
    assign w_idx   = w_ph[OW] ? (IW'(SINE_TABLE_DEPTH) - w_j) : w_j;

    // round half up, add center, saturate
    assign w_sprod  = r_neg3 ? -$signed({2'b00, r_prod}) : $signed({2'b00, r_prod});
    assign w_round  = w_sprod + 32'sd16384;
    assign w_shift  = w_round >>> 15;
    assign w_center = r_ax3 ? r_cy : r_cx;
    assign w_sum    = {{2{w_center[CW-1]}}, w_center} + SW'(w_shift);
    assign w_sat    = sat_coord({{(64-SW){w_sum[SW-1]}}, w_sum});

    assign w_cur_clip = r_clip_x | r_clip_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= i_cmd.issue_x | i_cmd.issue_y;
            r_v2    <= r_v1;
            r_v3    <= r_v2;
            r_valid <= i_cmd.emit_final | (i_cmd.store & (r_k != '0));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cx     <= i_center_x;
            r_cy     <= i_center_y;
            r_rx     <= i_radius_horizontal;
            r_ry     <= i_radius_vertical;
            r_n      <= w_n_in;
            r_apex_x <= w_apex_x_sat[CW-1:0];
            r_apex_y <= w_apex_y_sat[CW-1:0];
            r_aclip  <= w_apex_x_sat[CW] | w_apex_y_sat[CW];
            r_quo    <= QW'(1) << PW;
            r_rem    <= '0;
            r_phase  <= '0;
            r_frac   <= '0;
            r_k      <= '0;
        end
        if (i_cmd.div_step) begin
            r_quo <= {r_quo[QW-2:0], w_qbit};
            r_rem <= w_rem_next;
        end

        r_ax1  <= i_cmd.issue_y;
        r_neg1 <= w_ph[PW-1];
        r_idx  <= w_idx;

        r_ax2  <= r_ax1;
        r_neg2 <= r_neg1;
        r_trig <= w_rom[r_idx];

        r_ax3  <= r_ax2;
        r_neg3 <= r_neg2;
        r_prod <= (RW+TW)'(r_ax2 ? r_ry : r_rx) * (RW+TW)'(r_trig);

        if (r_v3) begin
            if (r_ax3) begin
                r_cur_y  <= w_sat[CW-1:0];
                r_clip_y <= w_sat[CW];
            end else begin
                r_cur_x  <= w_sat[CW-1:0];
                r_clip_x <= w_sat[CW];
            end
        end

        if (i_cmd.store) begin
            r_prev_x    <= r_cur_x;
            r_prev_y    <= r_cur_y;
            r_prev_clip <= w_cur_clip;
            if (r_k == '0) begin
                r_v0_x    <= r_cur_x;
                r_v0_y    <= r_cur_y;
                r_v0_clip <= w_cur_clip;
            end else begin
                r_out_ax    <= r_apex_x;
                r_out_ay    <= r_apex_y;
                r_out_a_x   <= r_prev_x;
                r_out_a_y   <= r_prev_y;
                r_out_b_x   <= r_cur_x;
                r_out_b_y   <= r_cur_y;
                r_out_clip  <= r_aclip | r_prev_clip | w_cur_clip;
                r_out_final <= 1'b0;
            end
            r_k     <= r_k + 1'b1;
            r_frac  <= w_carry ? NW'(w_frac_sum - {1'b0, r_n}) : w_frac_sum[NW-1:0];
            r_phase <= r_phase + r_quo[PW-1:0] + PW'(w_carry);
        end

        // closing triangle wraps back to rim vertex zero
        if (i_cmd.emit_final) begin
            r_out_ax    <= r_apex_x;
            r_out_ay    <= r_apex_y;
            r_out_a_x   <= r_prev_x;
            r_out_a_y   <= r_prev_y;
            r_out_b_x   <= r_v0_x;
            r_out_b_y   <= r_v0_y;
            r_out_clip  <= r_aclip | r_prev_clip | r_v0_clip;
            r_out_final <= 1'b1;
        end
    end

    assign o_status.empty = (i_segment_count == '0);
    assign o_status.last  = (r_k == r_n - 1'b1);

    assign o_result_valid   = r_valid;
    assign o_apex_x         = r_out_ax;
    assign o_apex_y         = r_out_ay;
    assign o_rim_a_x        = r_out_a_x;
    assign o_rim_a_y        = r_out_a_y;
    assign o_rim_b_x        = r_out_b_x;
    assign o_rim_b_y        = r_out_b_y;
    assign o_clipped        = r_out_clip;
    assign o_final_triangle = r_out_final;

endmodule

### design/etf_checker.sv
// port-level checker for the triangle fan generator and its bind
module etf_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic [etf_pkg::COUNT_W-1:0]         i_segment_count,
    input logic                                o_result_valid,
    input logic                                o_final_triangle
);

    // a non-empty item keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_segment_count != '0) |=> busy)
        else $error("busy not raised after a non-empty item");

    // beats before the last one come while the item is still in flight
    a_mid_beat_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_final_triangle |-> busy)
        else $error("non-final beat shown while idle");

    // the last beat coincides with the return to idle
    a_final_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_final_triangle |-> !busy)
        else $error("busy still high on the last beat");

    // no beat in the first busy cycle of an item
    a_start_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> !o_result_valid)
        else $error("beat shown as an item starts");

    // reset leaves the block idle and quiet
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_result_valid)
        else $error("block not idle after reset");

endmodule

bind ellipse_triangle_fan_generator etf_checker u_etf_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_segment_count  (i_segment_count),
    .o_result_valid   (o_result_valid),
    .o_final_triangle (o_final_triangle)
);
